FILE: rtl/ewk_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ewk_pkg
// Types and constants shared by the four-level EPT walker modules.
// ----------------------------------------------------------------------------
package ewk_pkg;

  localparam int unsigned Levels     = 4;
  localparam int unsigned IndexBits  = 9;
  localparam int unsigned PageBits   = 12;
  localparam int unsigned MaxPaBits  = 52;
  localparam int unsigned FrameBits  = 40;
  localparam int unsigned GaddrBits  = 48;
  localparam int unsigned QualBits   = 32;
  localparam int unsigned LevelBits  = 3;
  localparam int unsigned OrderBits  = 5;

  // input command codes
  localparam logic CMD_TRANSLATE = 1'b0;
  localparam logic CMD_RESPONSE  = 1'b1;

  // result kinds
  localparam logic KIND_REQUEST = 1'b0;
  localparam logic KIND_FINAL   = 1'b1;

  // entry read status codes
  localparam logic [1:0] RD_OK       = 2'd0;
  localparam logic [1:0] RD_PAGED    = 2'd1;
  localparam logic [1:0] RD_MAP_FAIL = 2'd2;

  // result status codes
  localparam logic [1:0] ST_SUCCESS   = 2'd0;
  localparam logic [1:0] ST_VIOLATION = 2'd1;
  localparam logic [1:0] ST_MISCONFIG = 2'd2;
  localparam logic [1:0] ST_RETRY     = 2'd3;

  // exit reasons
  localparam logic [1:0] RSN_NONE      = 2'd0;
  localparam logic [1:0] RSN_VIOLATION = 2'd1;
  localparam logic [1:0] RSN_MISCONFIG = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_ROOT_FRAME = 2'd0;
  localparam logic [1:0] CFG_PA_BITS    = 2'd1;
  localparam logic [1:0] CFG_EXEC_ONLY  = 2'd2;

  localparam logic [LevelBits-1:0] LEVEL_TOP = LevelBits'(Levels);
  localparam logic [LevelBits-1:0] LEVEL_1G  = 3'd3;
  localparam logic [LevelBits-1:0] LEVEL_2M  = 3'd2;
  localparam logic [LevelBits-1:0] LEVEL_4K  = 3'd1;

  localparam logic [OrderBits-1:0] ORDER_4K = 5'd0;
  localparam logic [OrderBits-1:0] ORDER_2M = 5'd9;
  localparam logic [OrderBits-1:0] ORDER_1G = 5'd18;

  localparam logic [63:0] EMT_IPAT_MASK = 64'h0000_0000_0000_0078;
  localparam logic [63:0] EMT_IPAT_SP   = 64'h0000_0000_0000_00f8;
  localparam logic [63:0] SP1G_RSV_MASK = 64'h0000_0000_3fff_f000;
  localparam logic [63:0] SP2M_RSV_MASK = 64'h0000_0000_001f_f000;

  localparam logic [2:0] RWX_ALL = 3'b111;

  typedef struct packed {
    logic [FrameBits-1:0] root_frame;
    logic [5:0]           phys_addr_bits;
    logic                 exec_only_allowed;
  } cfg_t;

  typedef struct packed {
    logic                  busy;
    logic [LevelBits-1:0]  walk_level;
    logic [FrameBits-1:0]  table_frame;
    logic [GaddrBits-1:0]  held_addr;
    logic [2:0]            held_access;
    logic [2:0]            rwx_so_far;
    logic [QualBits-1:0]   held_qual;
  } walk_t;

  typedef struct packed {
    logic                  kind;
    logic [MaxPaBits-1:0]  read_addr;
    logic [1:0]            status;
    logic [FrameBits-1:0]  frame_number;
    logic [OrderBits-1:0]  map_order;
    logic [2:0]            granted_rwx;
    logic [QualBits-1:0]   exit_info;
    logic [1:0]            exit_cause;
  } res_t;

endpackage
`default_nettype wire

FILE: rtl/ewk_step.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ewk_step
// One walk step: entry checks, rights merge, next state and result.
// ----------------------------------------------------------------------------
module ewk_step (
  input  var ewk_pkg::walk_t               st_i,
  input  var ewk_pkg::cfg_t                cfg_i,
  input  wire                              command_i,
  input  wire [ewk_pkg::GaddrBits-1:0]     guest_addr_i,
  input  wire [2:0]                        access_rwx_i,
  input  wire [ewk_pkg::QualBits-1:0]      prior_qual_i,
  input  wire [63:0]                       entry_word_i,
  input  wire [1:0]                        read_status_i,
  output ewk_pkg::walk_t                   st_o,
  output logic                             res_valid_o,
  output ewk_pkg::res_t                    res_o
);

  function automatic logic [ewk_pkg::IndexBits-1:0] level_index(
    input logic [ewk_pkg::GaddrBits-1:0] addr,
    input logic [ewk_pkg::LevelBits-1:0] lvl
  );
    logic [ewk_pkg::IndexBits-1:0] idx;
    case (lvl)
      ewk_pkg::LEVEL_TOP: idx = addr[47:39];
      ewk_pkg::LEVEL_1G:  idx = addr[38:30];
      ewk_pkg::LEVEL_2M:  idx = addr[29:21];
      default:            idx = addr[20:12];
    endcase
    return idx;
  endfunction

  logic [2:0]                     rwx_e;
  logic [2:0]                     emt;
  logic                           sp;
  logic [ewk_pkg::LevelBits-1:0]  lvl;
  logic [ewk_pkg::LevelBits-1:0]  lvl_dn;
  logic [63:0]                    rsv;
  logic                           misconf;
  logic [2:0]                     rwx_new;
  logic [ewk_pkg::FrameBits-1:0]  frame;
  logic [ewk_pkg::FrameBits-1:0]  leaf_frame;
  logic [ewk_pkg::OrderBits-1:0]  order;
  logic                           is_leaf;
  logic                           allowed;

  assign rwx_e  = entry_word_i[2:0];
  assign emt    = entry_word_i[5:3];
  assign sp     = entry_word_i[7];
  assign lvl    = st_i.walk_level;
  assign lvl_dn = lvl - 3'd1;
  assign frame  = entry_word_i[51:12];

  // reserved bit mask for this level
  always_comb begin
    rsv = '0;
    for (int i = ewk_pkg::PageBits; i < ewk_pkg::MaxPaBits; i++) begin
      rsv[i] = (cfg_i.phys_addr_bits <= 6'(i));
    end
    case (lvl)
      ewk_pkg::LEVEL_TOP: rsv = rsv | ewk_pkg::EMT_IPAT_SP;
      ewk_pkg::LEVEL_1G:  rsv = rsv | (sp ? ewk_pkg::SP1G_RSV_MASK : ewk_pkg::EMT_IPAT_MASK);
      ewk_pkg::LEVEL_2M:  rsv = rsv | (sp ? ewk_pkg::SP2M_RSV_MASK : ewk_pkg::EMT_IPAT_MASK);
      default:            rsv = rsv;
    endcase
  end

  assign misconf = (|(entry_word_i & rsv))
                || ((sp || lvl == ewk_pkg::LEVEL_4K)
                    && (emt == 3'd2 || emt == 3'd3 || emt == 3'd7))
                || (rwx_e == 3'b010) || (rwx_e == 3'b110)
                || (rwx_e == 3'b100 && !cfg_i.exec_only_allowed);

  assign rwx_new = st_i.rwx_so_far & rwx_e;

  // leaf decode: 4K leaf, or 1G / 2M superpage with the guest offset bits spliced in
  always_comb begin
    is_leaf    = 1'b0;
    order      = ewk_pkg::ORDER_4K;
    leaf_frame = frame;
    if (lvl == ewk_pkg::LEVEL_1G && sp) begin
      is_leaf    = 1'b1;
      order      = ewk_pkg::ORDER_1G;
      leaf_frame = {frame[39:18], st_i.held_addr[29:12]};
    end else if (lvl == ewk_pkg::LEVEL_2M && sp) begin
      is_leaf    = 1'b1;
      order      = ewk_pkg::ORDER_2M;
      leaf_frame = {frame[39:9], st_i.held_addr[20:12]};
    end else if (lvl <= ewk_pkg::LEVEL_4K) begin
      is_leaf    = 1'b1;
    end
  end

  assign allowed = ((st_i.held_access & ~rwx_new) == 3'b000);

  always_comb begin
    st_o        = st_i;
    res_valid_o = 1'b0;
    res_o       = '0;
    if (command_i == ewk_pkg::CMD_TRANSLATE) begin
      st_o.busy        = 1'b1;
      st_o.walk_level  = ewk_pkg::LEVEL_TOP;
      st_o.table_frame = cfg_i.root_frame;
      st_o.held_addr   = guest_addr_i;
      st_o.held_access = access_rwx_i;
      st_o.held_qual   = prior_qual_i;
      st_o.rwx_so_far  = ewk_pkg::RWX_ALL;
      res_valid_o      = 1'b1;
      res_o.kind       = ewk_pkg::KIND_REQUEST;
      res_o.read_addr  = {cfg_i.root_frame,
                          level_index(guest_addr_i, ewk_pkg::LEVEL_TOP), 3'b000};
    end else if (st_i.busy) begin
      res_valid_o        = 1'b1;
      res_o.kind         = ewk_pkg::KIND_FINAL;
      res_o.frame_number = '1;
      st_o.busy          = 1'b0;
      st_o.walk_level    = ewk_pkg::LEVEL_TOP;
      if (read_status_i == ewk_pkg::RD_PAGED) begin
        res_o.status    = ewk_pkg::ST_RETRY;
        res_o.exit_info = st_i.held_qual;
      end else if (read_status_i != ewk_pkg::RD_OK) begin
        res_o.status     = ewk_pkg::ST_MISCONFIG;
        res_o.exit_cause = ewk_pkg::RSN_MISCONFIG;
      end else if (rwx_e == 3'b000) begin
        res_o.status     = ewk_pkg::ST_VIOLATION;
        res_o.exit_cause = ewk_pkg::RSN_VIOLATION;
        res_o.exit_info  = {st_i.held_qual[31:6], 3'b000, st_i.held_access};
      end else if (misconf) begin
        res_o.status     = ewk_pkg::ST_MISCONFIG;
        res_o.exit_cause = ewk_pkg::RSN_MISCONFIG;
      end else begin
        st_o.rwx_so_far = rwx_new;
        if (!is_leaf) begin
          // descend one level
          st_o.busy          = 1'b1;
          st_o.walk_level    = lvl_dn;
          st_o.table_frame   = frame;
          res_o              = '0;
          res_o.kind         = ewk_pkg::KIND_REQUEST;
          res_o.read_addr    = {frame, level_index(st_i.held_addr, lvl_dn), 3'b000};
        end else begin
          res_o.map_order   = order;
          res_o.granted_rwx = rwx_new;
          if (allowed) begin
            res_o.status       = ewk_pkg::ST_SUCCESS;
            res_o.frame_number = leaf_frame;
            res_o.exit_info    = st_i.held_qual;
          end else begin
            res_o.status     = ewk_pkg::ST_VIOLATION;
            res_o.exit_cause = ewk_pkg::RSN_VIOLATION;
            res_o.exit_info  = {st_i.held_qual[31:6], rwx_new, st_i.held_access};
          end
        end
      end
    end
  end

endmodule
`default_nettype wire

FILE: rtl/ept_four_level_walker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ept_four_level_walker
// Four-level EPT walker: entry checks, superpages, rights merge, exit info.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries either a translate
//   command or a table entry read response. Output channel (out_valid_o /
//   out_stall_i) carries either an entry read request (kind 0) or the final
//   translation result (kind 1). A translate issues the level 4 read; each
//   response either issues the next level read or ends the walk.
//   A response arriving with no walk in progress is dropped silently.
//   Results are registered. Throughput: one item per cycle while
//   in_stall_o is low; all checks for an item sit in one combinational
//   pass (ewk_step) between the input port and the result register. Two
//   result slots (output register plus skid register) let the input keep
//   taking items while a finished result waits; in_stall_o rises only once
//   both slots are full, and is a pure register output.
//   Config: cfg_valid_i/cfg_ready_o write channel, always ready; write
//   only while no walk is outstanding and the output is drained.
//   Reset: walk idle at level 4, rights all ones, root frame 0, physical
//   address width 52, execute-only disallowed, both result slots empty.
// ----------------------------------------------------------------------------
module ept_four_level_walker (
  input  wire         clk_i,
  input  wire         rst_ni,
  // config write channel
  input  wire         cfg_valid_i,
  output logic        cfg_ready_o,
  input  wire [1:0]   cfg_index_i,
  input  wire [39:0]  cfg_data_i,
  // input channel
  input  wire         in_valid_i,
  output logic        in_stall_o,
  input  wire         command_i,
  input  wire [47:0]  guest_addr_i,
  input  wire [2:0]   access_rwx_i,
  input  wire [31:0]  prior_qual_i,
  input  wire [63:0]  entry_word_i,
  input  wire [1:0]   read_status_i,
  // output channel
  output logic        out_valid_o,
  input  wire         out_stall_i,
  output logic        kind_o,
  output logic [51:0] read_addr_o,
  output logic [1:0]  status_o,
  output logic [39:0] frame_number_o,
  output logic [4:0]  map_order_o,
  output logic [2:0]  granted_rwx_o,
  output logic [31:0] exit_info_o,
  output logic [1:0]  exit_cause_o
);

  ewk_pkg::cfg_t  cfg_q, cfg_d;
  ewk_pkg::walk_t walk_q, walk_d;
  ewk_pkg::walk_t step_st;
  ewk_pkg::res_t  step_res;
  logic           step_valid;

  // result slots
  ewk_pkg::res_t  out_q, out_d;
  ewk_pkg::res_t  skid_q, skid_d;
  logic           out_valid_q, out_valid_d;
  logic           skid_valid_q, skid_valid_d;

  logic in_xfer;
  logic cfg_xfer;
  logic new_res;
  logic slot_free;

  assign cfg_ready_o = 1'b1;
  assign cfg_xfer    = cfg_valid_i && cfg_ready_o;
  assign in_stall_o  = skid_valid_q;
  assign in_xfer     = in_valid_i && !skid_valid_q;

  // ---------------------------------------------------------------------------
  // Configuration registers; out-of-range indexes are ignored
  // ---------------------------------------------------------------------------
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_xfer) begin
      unique case (cfg_index_i)
        ewk_pkg::CFG_ROOT_FRAME: cfg_d.root_frame        = cfg_data_i;
        ewk_pkg::CFG_PA_BITS:    cfg_d.phys_addr_bits    = cfg_data_i[5:0];
        ewk_pkg::CFG_EXEC_ONLY:  cfg_d.exec_only_allowed = cfg_data_i[0];
        default:                 cfg_d = cfg_q;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Walk step
  // ---------------------------------------------------------------------------
  ewk_step u_step (
    .st_i          (walk_q),
    .cfg_i         (cfg_q),
    .command_i     (command_i),
    .guest_addr_i  (guest_addr_i),
    .access_rwx_i  (access_rwx_i),
    .prior_qual_i  (prior_qual_i),
    .entry_word_i  (entry_word_i),
    .read_status_i (read_status_i),
    .st_o          (step_st),
    .res_valid_o   (step_valid),
    .res_o         (step_res)
  );

  assign walk_d  = in_xfer ? step_st : walk_q;
  assign new_res = in_xfer && step_valid;

  // ---------------------------------------------------------------------------
  // Output register plus skid; skid only fills when output is stalled
  // ---------------------------------------------------------------------------
  assign slot_free = !out_valid_q || !out_stall_i;

  always_comb begin
    out_d        = out_q;
    skid_d       = skid_q;
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    if (slot_free) begin
      if (skid_valid_q) begin
        out_d        = skid_q;
        out_valid_d  = 1'b1;
        skid_valid_d = 1'b0;
      end else begin
        out_d       = step_res;
        out_valid_d = new_res;
      end
    end else if (new_res) begin
      skid_d       = step_res;
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.root_frame        <= '0;
      cfg_q.phys_addr_bits    <= 6'(ewk_pkg::MaxPaBits);
      cfg_q.exec_only_allowed <= 1'b0;
      walk_q.busy             <= 1'b0;
      walk_q.walk_level       <= ewk_pkg::LEVEL_TOP;
      walk_q.table_frame      <= '0;
      walk_q.held_addr        <= '0;
      walk_q.held_access      <= '0;
      walk_q.rwx_so_far       <= ewk_pkg::RWX_ALL;
      walk_q.held_qual        <= '0;
      out_valid_q             <= 1'b0;
      skid_valid_q            <= 1'b0;
    end else begin
      cfg_q        <= cfg_d;
      walk_q       <= walk_d;
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o    = out_valid_q;
  assign kind_o         = out_q.kind;
  assign read_addr_o    = out_q.read_addr;
  assign status_o       = out_q.status;
  assign frame_number_o = out_q.frame_number;
  assign map_order_o    = out_q.map_order;
  assign granted_rwx_o  = out_q.granted_rwx;
  assign exit_info_o    = out_q.exit_info;
  assign exit_cause_o   = out_q.exit_cause;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid slot full while output slot empty");

  a_idle_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !walk_q.busy |-> (walk_q.walk_level == ewk_pkg::LEVEL_TOP))
    else $error("idle walker not parked at top level");

  a_translate_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && command_i == ewk_pkg::CMD_TRANSLATE) |=> walk_q.busy)
    else $error("translate transfer did not start a walk");

  a_final_ends_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (new_res && step_res.kind == ewk_pkg::KIND_FINAL) |=> !walk_q.busy)
    else $error("final result left walk busy");

  a_request_keeps_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (new_res && step_res.kind == ewk_pkg::KIND_REQUEST) |=> walk_q.busy)
    else $error("read request issued with no walk in progress");

endmodule
`default_nettype wire

FILE: tb/sv/ewk_tb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ewk_tb_pkg
// Scoreboard for the EPT walker: tracks the walk and queues its outputs.
// ----------------------------------------------------------------------------
package ewk_tb_pkg;
  import ewk_pkg::*;

  class walk_scoreboard;
    // register copy
    logic [FrameBits-1:0] root_frm;
    logic [5:0]           pa_width;
    logic                 xo_legal;
    // walk in progress
    logic                 walking;
    logic [LevelBits-1:0] level;
    logic [FrameBits-1:0] tbl_frm;
    logic [GaddrBits-1:0] gpa;
    logic [2:0]           want_rwx;
    logic [2:0]           rights;
    logic [QualBits-1:0]  qual_in;
    // outputs still owed by the block, oldest first
    res_t                 walk_out_q[$];
    int unsigned          n_errors;
    int unsigned          n_checked;
    int unsigned          n_inputs;
    int unsigned          n_ignored;
    int unsigned          n_status[4];

    function new();
      root_frm  = '0;
      pa_width  = 6'(MaxPaBits);
      xo_legal  = 1'b0;
      walking   = 1'b0;
      level     = LEVEL_TOP;
      tbl_frm   = '0;
      gpa       = '0;
      want_rwx  = '0;
      rights    = RWX_ALL;
      qual_in   = '0;
      n_errors  = 0;
      n_checked = 0;
      n_inputs  = 0;
      n_ignored = 0;
      foreach (n_status[i]) n_status[i] = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [39:0] data);
      case (idx)
        CFG_ROOT_FRAME: root_frm = data;
        CFG_PA_BITS:    pa_width = data[5:0];
        CFG_EXEC_ONLY:  xo_legal = data[0];
        default: ;
      endcase
    endfunction

    function int unsigned pending();
      return walk_out_q.size();
    endfunction

    function logic [MaxPaBits-1:0] entry_addr_of(logic [FrameBits-1:0] frm,
                                                 logic [LevelBits-1:0] lvl);
      int unsigned sh;
      logic [IndexBits-1:0] idx;
      sh  = PageBits + IndexBits * (lvl - 1);
      idx = IndexBits'(gpa >> sh);
      return {frm, idx, 3'b000};
    endfunction

    // reserved-bit, memory-type and rights-combination checks
    function bit entry_misconfigured(logic [63:0] e, logic [LevelBits-1:0] lvl);
      int unsigned pab;
      logic [63:0] rsv;
      logic [2:0]  emt;
      bit          sp;
      pab = (pa_width < PageBits) ? PageBits : pa_width;
      rsv = '0;
      if (pab < MaxPaBits)
        rsv = ((64'd1 << MaxPaBits) - 64'd1) & ~((64'd1 << pab) - 64'd1);
      sp  = e[7];
      emt = e[5:3];
      if (lvl == LEVEL_TOP) begin
        rsv |= 64'hf8;
      end else if (lvl == LEVEL_1G || lvl == LEVEL_2M) begin
        if (sp) rsv |= ((64'd1 << (IndexBits * (lvl - 1))) - 64'd1) << PageBits;
        else    rsv |= 64'h78;
      end
      if ((e & rsv) != 0) return 1'b1;
      if ((sp || lvl == LEVEL_4K) && (emt == 3'd2 || emt == 3'd3 || emt == 3'd7))
        return 1'b1;
      if (e[2:0] == 3'b010 || e[2:0] == 3'b110) return 1'b1;
      if (e[2:0] == 3'b100 && !xo_legal) return 1'b1;
      return 1'b0;
    endfunction

    function void issue_read(logic [MaxPaBits-1:0] addr);
      res_t r;
      r           = '0;
      r.kind      = KIND_REQUEST;
      r.read_addr = addr;
      walk_out_q.push_back(r);
    endfunction

    function void end_walk(logic [1:0] st, logic [FrameBits-1:0] frm,
                           logic [OrderBits-1:0] order, logic [2:0] rwx,
                           logic [QualBits-1:0] qual, logic [1:0] reason);
      res_t r;
      r.kind         = KIND_FINAL;
      r.read_addr    = '0;
      r.status       = st;
      r.frame_number = frm;
      r.map_order    = order;
      r.granted_rwx  = rwx;
      r.exit_info    = qual;
      r.exit_cause   = reason;
      walk_out_q.push_back(r);
      walking = 1'b0;
      level   = LEVEL_TOP;
    endfunction

    function void take_input(logic cmd, logic [GaddrBits-1:0] ga, logic [2:0] acc,
                             logic [QualBits-1:0] qual, logic [63:0] e,
                             logic [1:0] rd_st);
      logic [FrameBits-1:0] frm;
      logic [FrameBits-1:0] msk;
      logic [OrderBits-1:0] order;
      n_inputs++;
      if (cmd == CMD_TRANSLATE) begin
        walking  = 1'b1;
        level    = LEVEL_TOP;
        tbl_frm  = root_frm;
        gpa      = ga;
        want_rwx = acc;
        qual_in  = qual;
        rights   = RWX_ALL;
        issue_read(entry_addr_of(tbl_frm, level));
        return;
      end
      if (!walking) begin
        n_ignored++;
        return;
      end
      if (rd_st == RD_PAGED) begin
        end_walk(ST_RETRY, '1, ORDER_4K, 3'b000, qual_in, RSN_NONE);
      end else if (rd_st != RD_OK) begin
        end_walk(ST_MISCONFIG, '1, ORDER_4K, 3'b000, '0, RSN_MISCONFIG);
      end else if (e[2:0] == 3'b000) begin
        end_walk(ST_VIOLATION, '1, ORDER_4K, 3'b000,
                 {qual_in[31:6], 3'b000, want_rwx}, RSN_VIOLATION);
      end else if (entry_misconfigured(e, level)) begin
        end_walk(ST_MISCONFIG, '1, ORDER_4K, 3'b000, '0, RSN_MISCONFIG);
      end else begin
        rights &= e[2:0];
        frm = e[51:12];
        if ((level == LEVEL_1G || level == LEVEL_2M) && e[7]) begin
          msk   = (40'd1 << (IndexBits * (level - 1))) - 40'd1;
          frm   = (frm & ~msk) + (FrameBits'(gpa >> PageBits) & msk);
          order = OrderBits'(IndexBits * (level - 1));
        end else if (level == LEVEL_4K) begin
          order = ORDER_4K;
        end else begin
          tbl_frm = frm;
          level   = level - 3'd1;
          issue_read(entry_addr_of(tbl_frm, level));
          return;
        end
        if ((want_rwx & ~rights) == 3'b000)
          end_walk(ST_SUCCESS, frm, order, rights, qual_in, RSN_NONE);
        else
          end_walk(ST_VIOLATION, '1, order, rights,
                   {qual_in[31:6], rights, want_rwx}, RSN_VIOLATION);
      end
    endfunction

    function void diff_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
      if (exp_v !== act_v) begin
        n_errors++;
        $display("%0t: %s mismatch: expected %h, actual %h", $time, name, exp_v, act_v);
      end
    endfunction

    function void match_output(res_t got);
      res_t w;
      if (walk_out_q.size() == 0) begin
        n_errors++;
        $display("%0t: result with nothing outstanding: kind %0d addr %h status %0d",
                 $time, got.kind, got.read_addr, got.status);
        return;
      end
      w = walk_out_q.pop_front();
      n_checked++;
      if (w.kind == KIND_FINAL) n_status[w.status]++;
      diff_field("kind",         w.kind,         got.kind);
      diff_field("read_addr",    w.read_addr,    got.read_addr);
      diff_field("status",       w.status,       got.status);
      diff_field("frame_number", w.frame_number, got.frame_number);
      diff_field("map_order",    w.map_order,    got.map_order);
      diff_field("granted_rwx",  w.granted_rwx,  got.granted_rwx);
      diff_field("exit_info",    w.exit_info,    got.exit_info);
      diff_field("exit_cause",   w.exit_cause,   got.exit_cause);
    endfunction

    function void flush_leftover();
      if (walk_out_q.size() != 0) begin
        n_errors += walk_out_q.size();
        $display("%0t: %0d expected results never arrived", $time, walk_out_q.size());
        walk_out_q.delete();
      end
    endfunction
  endclass

endpackage

FILE: tb/sv/ept_four_level_walker_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ept_four_level_walker_tb
// Self-checking bench for the four-level EPT walker. Directed walks hit the
// read status codes, non-present and misconfigured entries, 4K, 2M and 1G
// mappings and a restart mid-walk; then random walks, mostly well formed,
// run under several register settings with random stalls on both channels.
// ----------------------------------------------------------------------------
module ept_four_level_walker_tb;
  import ewk_pkg::*;
  import ewk_tb_pkg::*;

  localparam int unsigned PHASES      = 6;
  localparam int unsigned PHASE_ITEMS = 275;  // 6 x 275 random transfers
  localparam int unsigned DRAIN_LIMIT = 5000;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i;
  logic [39:0] cfg_data_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic        command_i;
  logic [47:0] guest_addr_i;
  logic [2:0]  access_rwx_i;
  logic [31:0] prior_qual_i;
  logic [63:0] entry_word_i;
  logic [1:0]  read_status_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic        kind_o;
  logic [51:0] read_addr_o;
  logic [1:0]  status_o;
  logic [39:0] frame_number_o;
  logic [4:0]  map_order_o;
  logic [2:0]  granted_rwx_o;
  logic [31:0] exit_info_o;
  logic [1:0]  exit_cause_o;

  res_t           seen;
  walk_scoreboard sb;
  bit             tx_idle_en;    // sender inserts gaps
  bit             rx_idle_en;    // receiver stalls
  int unsigned    n_settings;

  ept_four_level_walker u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .command_i      (command_i),
    .guest_addr_i   (guest_addr_i),
    .access_rwx_i   (access_rwx_i),
    .prior_qual_i   (prior_qual_i),
    .entry_word_i   (entry_word_i),
    .read_status_i  (read_status_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .kind_o         (kind_o),
    .read_addr_o    (read_addr_o),
    .status_o       (status_o),
    .frame_number_o (frame_number_o),
    .map_order_o    (map_order_o),
    .granted_rwx_o  (granted_rwx_o),
    .exit_info_o    (exit_info_o),
    .exit_cause_o   (exit_cause_o)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Hard stop; far above the slowest legal run.
  initial begin
    #10_000_000;
    $display("FAIL");
    $finish;
  end

  // Output port packed in the same field order as res_t.
  assign seen = {kind_o, read_addr_o, status_o, frame_number_o, map_order_o,
                 granted_rwx_o, exit_info_o, exit_cause_o};

  // Result monitor: outputs are sampled at the edge, before the block's own
  // updates land, so each transfer is seen exactly once.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.match_output(seen);
  end

  // Gap lengths: mostly short, now and then long.
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 93) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [63:0] rnd64();
    return {$urandom(), $urandom()};
  endfunction

  // Receiver: runs of accept, then (when enabled) a stall of random length.
  initial begin
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      out_stall_i <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
      if (rx_idle_en) begin
        out_stall_i <= 1'b1;
        repeat (idle_len()) @(posedge clk_i);
      end
    end
  end

  // A legal entry for the given level under the current settings. Ignored
  // bits (8-11, 52-63, IPAT where allowed) stay random.
  function automatic logic [63:0] good_entry(logic [LevelBits-1:0] lvl);
    logic [63:0] e;
    logic [2:0]  rwx;
    logic [2:0]  emt;
    int unsigned pab;
    int unsigned k;
    pab = (sb.pa_width < PageBits) ? PageBits : sb.pa_width;
    e   = rnd64();
    if (pab < MaxPaBits)
      e &= ~(((64'd1 << MaxPaBits) - 64'd1) & ~((64'd1 << pab) - 64'd1));
    case ($urandom_range(0, 5))
      0:       rwx = 3'b001;
      1:       rwx = 3'b011;
      2:       rwx = 3'b101;
      3:       rwx = sb.xo_legal ? 3'b100 : 3'b111;
      default: rwx = 3'b111;
    endcase
    case ($urandom_range(0, 4))
      0:       emt = 3'd0;
      1:       emt = 3'd1;
      2:       emt = 3'd4;
      3:       emt = 3'd5;
      default: emt = 3'd6;
    endcase
    e[2:0] = rwx;
    e[5:3] = emt;
    if (lvl == LEVEL_TOP) begin
      e[7:3] = 5'b0;
    end else if (lvl == LEVEL_1G || lvl == LEVEL_2M) begin
      if ($urandom_range(0, 3) == 0) begin
        // superpage: frame aligned to the page size
        e[7] = 1'b1;
        k    = IndexBits * (lvl - 1);
        e   &= ~(((64'd1 << k) - 64'd1) << PageBits);
      end else begin
        e[7:3] = 5'b0;
      end
    end
    return e;
  endfunction

  // A legal entry with one field altered, mostly into a defect, or plain noise.
  function automatic logic [63:0] broken_entry(logic [LevelBits-1:0] lvl);
    logic [63:0] e;
    int unsigned pab;
    pab = (sb.pa_width < PageBits) ? PageBits : sb.pa_width;
    e   = good_entry(lvl);
    case ($urandom_range(0, 6))
      0: e = rnd64();
      1: e[2:0] = 3'b000;                                   // not present
      2: e[2:0] = $urandom_range(0, 1) ? 3'b010 : 3'b110;   // write without read
      3: e[2:0] = 3'b100;                                   // execute only
      4: begin                                              // reserved memory type
        e[7] = 1'b1;
        case ($urandom_range(0, 2))
          0:       e[5:3] = 3'd2;
          1:       e[5:3] = 3'd3;
          default: e[5:3] = 3'd7;
        endcase
      end
      5: begin                                              // address above PA width, else a low bit
        if (pab < MaxPaBits) e[$urandom_range(pab, MaxPaBits - 1)] = 1'b1;
        else                 e[$urandom_range(3, 7)] = 1'b1;
      end
      default: e[$urandom_range(3, 7)] = 1'b1;
    endcase
    return e;
  endfunction

  // One input transfer; returns at the edge that took it, valid still high.
  // The caller either drives the next item at once or calls tx_pause/drain.
  task automatic send(input logic cmd, input logic [47:0] ga, input logic [2:0] acc,
                      input logic [31:0] q, input logic [63:0] e,
                      input logic [1:0] rd_st);
    in_valid_i    <= 1'b1;
    command_i     <= cmd;
    guest_addr_i  <= ga;
    access_rwx_i  <= acc;
    prior_qual_i  <= q;
    entry_word_i  <= e;
    read_status_i <= rd_st;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.take_input(cmd, ga, acc, q, e, rd_st);
  endtask

  // Unused fields of each command carry random values.
  task automatic translate(input logic [47:0] ga, input logic [2:0] acc,
                           input logic [31:0] q);
    send(CMD_TRANSLATE, ga, acc, q, rnd64(), 2'($urandom_range(0, 2)));
  endtask

  task automatic respond(input logic [63:0] e, input logic [1:0] rd_st);
    send(CMD_RESPONSE, 48'(rnd64()), 3'($urandom_range(0, 7)), $urandom(), e, rd_st);
  endtask

  task automatic tx_pause(input int unsigned n);
    if (n != 0) begin
      in_valid_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // Hold the sender until every owed result is out or DRAIN_LIMIT is hit, then
  // wait on so a dropped response has surely passed through.
  task automatic drain();
    int unsigned waited;
    in_valid_i <= 1'b0;
    waited = 0;
    while (sb.pending() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (4) @(posedge clk_i);
    sb.flush_leftover();
  endtask

  // Close any open walk, drain, then write all three registers back to back.
  task automatic apply_setting(input logic [39:0] root, input logic [5:0] pab,
                               input logic xo);
    logic [1:0]  idx [3];
    logic [39:0] val [3];
    idx[0] = CFG_ROOT_FRAME; val[0] = root;
    idx[1] = CFG_PA_BITS;    val[1] = 40'(pab);
    idx[2] = CFG_EXEC_ONLY;  val[2] = 40'(xo);
    if (sb.walking) respond(rnd64(), RD_PAGED);
    drain();
    for (int i = 0; i < 3; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx[i];
      cfg_data_i  <= val[i];
      @(posedge clk_i);
      while (!cfg_ready_o) @(posedge clk_i);
      sb.write_reg(idx[i], val[i]);
    end
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
    n_settings++;
  endtask

  initial begin
    int unsigned n;
    int unsigned r;
    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = CFG_ROOT_FRAME;
    cfg_data_i    = '0;
    in_valid_i    = 1'b0;
    command_i     = CMD_TRANSLATE;
    guest_addr_i  = '0;
    access_rwx_i  = '0;
    prior_qual_i  = '0;
    entry_word_i  = '0;
    read_status_i = RD_OK;
    tx_idle_en    = 1'b0;
    rx_idle_en    = 1'b1;
    n_settings    = 0;
    sb            = new();

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // ---- directed walks: root all ones, PA width 52, no execute-only ----
    apply_setting('1, 6'd52, 1'b0);
    respond('1, RD_OK);                                 // nothing open: dropped
    translate('1, 3'b111, '1);
    respond(rnd64(), RD_PAGED);                         // retry, qual kept
    translate('0, 3'b000, '0);
    respond('1, RD_MAP_FAIL);                           // mapping failure
    translate(48'h8000_4020_1008, 3'b011, 32'hdead_beef);
    respond(64'hffff_ffff_ffff_fff8, RD_OK);            // not present
    translate(48'h1234_5678_9abc, 3'b001, $urandom());
    respond(64'h0000_0000_0000_1087, RD_OK);            // superpage bit at level 4
    translate(48'h0fed_cba9_8765, 3'b001, $urandom());
    respond(64'h0000_0000_0000_2002, RD_OK);            // write only
    translate(48'h7777_0000_ffff, 3'b100, $urandom());
    respond(64'h0000_0000_0000_3004, RD_OK);            // execute only, not allowed
    // full 4K walk, every frame bit set
    translate('1, 3'b111, '1);
    respond(64'h000f_ffff_ffff_f007, RD_OK);
    respond(64'h000f_ffff_ffff_f007, RD_OK);
    respond(64'h000f_ffff_ffff_f007, RD_OK);
    respond(64'hffff_ffff_ffff_ff77, RD_OK);
    // restart mid-walk, then a 1G mapping
    translate(48'h0000_5555_aaaa, 3'b111, $urandom());
    respond(64'h000f_ffff_ffff_f007, RD_OK);
    translate(48'hffff_ffff_ffff, 3'b001, $urandom());
    respond(64'h000f_ffff_ffff_f007, RD_OK);
    respond(64'h000f_ffff_c000_00b3, RD_OK);
    // 2M mapping without write right: violation keeps the page order
    translate(48'h3c3c_3c3c_3c3c, 3'b010, '1);
    respond(64'h000f_ffff_ffff_f007, RD_OK);
    respond(64'h000f_ffff_ffff_f007, RD_OK);
    respond(64'h000f_ffff_ffe0_0085, RD_OK);

    // ---- random walks under a series of register settings ----
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0:       apply_setting(40'(rnd64()), 6'd52, 1'b0);
        1:       apply_setting('1, 6'd32, 1'b1);
        2:       apply_setting('0, 6'($urandom_range(33, 51)), 1'b1);
        3:       apply_setting(40'(rnd64()), 6'd52, 1'b1);
        4:       apply_setting(40'(rnd64()), 6'd32, 1'b0);
        default: apply_setting(40'(rnd64()), 6'($urandom_range(32, 52)),
                               1'($urandom_range(0, 1)));
      endcase
      // idle patterns rotate: both sides, none, sender only, receiver only
      tx_idle_en = (ph % 4 == 0) || (ph % 4 == 2);
      rx_idle_en = (ph % 4 == 0) || (ph % 4 == 3);
      n = 0;
      while (n < PHASE_ITEMS) begin
        if (!sb.walking) begin
          if ($urandom_range(0, 19) == 0) begin
            respond(rnd64(), RD_OK);                    // stray response, dropped
          end else begin
            translate(48'(rnd64()), 3'($urandom_range(0, 7)), $urandom());
            n++;
          end
        end else begin
          r = $urandom_range(0, 99);
          if (r < 5)
            translate(48'(rnd64()), 3'($urandom_range(0, 7)), $urandom());
          else if (r < 7)
            respond(rnd64(), RD_PAGED);
          else if (r < 9)
            respond(rnd64(), RD_MAP_FAIL);
          else if (r < 25)
            respond(broken_entry(sb.level), RD_OK);
          else
            respond(good_entry(sb.level), RD_OK);
          n++;
        end
        if (tx_idle_en && $urandom_range(0, 2) == 0) tx_pause(idle_len());
        // occasionally let the pipe run dry before going on
        if ($urandom_range(0, 299) == 0) drain();
      end
    end

    drain();
    $display("Walker run: %0d inputs (%0d dropped), %0d settings, %0d results checked.",
             sb.n_inputs, sb.n_ignored, n_settings, sb.n_checked);
    $display("Walk outcomes: %0d success, %0d violation, %0d misconfig, %0d retry.",
             sb.n_status[ST_SUCCESS], sb.n_status[ST_VIOLATION],
             sb.n_status[ST_MISCONFIG], sb.n_status[ST_RETRY]);
    if (sb.n_errors == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
